>>> hw/rtl/scp_pkg.sv
// Shared types, constants and decode helpers for the system control coprocessor registers.
package scp_pkg;

    localparam logic       REQ_READ  = 1'b0;
    localparam logic       REQ_WRITE = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_WR_UNK    = 2'd1;
    localparam logic [1:0] ST_RD_UNK    = 2'd2;
    localparam logic [1:0] ST_FORBIDDEN = 2'd3;

    localparam int         PADDR_W      = 3;
    localparam logic [0:0] REG_VARIANT  = 1'b0;

    localparam logic [31:0] MIDR_V0      = 32'h410f_c083;
    localparam logic [31:0] MIDR_V1      = 32'h414f_c091;
    localparam logic [31:0] CTR_V0       = 32'h8204_8004;
    localparam logic [31:0] CTR_V1       = 32'h8333_8003;
    localparam logic [31:0] CCSID_L0     = 32'he007_e01a;
    localparam logic [31:0] CCSID_L1     = 32'h2007_e01a;
    localparam logic [31:0] CCSID_L2     = 32'hf000_0000;
    localparam logic [31:0] CLIDR_VAL    = 32'h0a00_0023;
    localparam logic [31:0] MPIDR_VAL    = 32'h8000_0000;
    localparam logic [10:0] CTRL_FIXED   = 11'h314;
    localparam logic [31:0] CBAR_VAL     = 32'h1f00_0000;
    localparam logic [31:0] PFR0_VAL     = 32'h0000_1131;
    localparam logic [31:0] MMFR0_VAL    = 32'h3110_0003;
    localparam logic [31:0] MMFR1_VAL    = 32'h2000_0000;
    localparam logic [31:0] MMFR3_VAL    = 32'h0000_0211;
    localparam logic [31:0] ISAR0_VAL    = 32'h0010_1111;
    localparam logic [31:0] ISAR3_VAL    = 32'h1111_2131;
    localparam logic [31:0] CSTAT_VAL    = 32'h4000_0000;
    localparam logic [31:0] TCM_RESET    = 32'h0000_0014;
    localparam logic [31:0] CTRL_BAD_MSK = 32'h6200_0002;

    typedef struct packed {
        logic        req_type;
        logic [3:0]  crn;
        logic [2:0]  op1;
        logic [3:0]  crm;
        logic [2:0]  op2;
        logic [31:0] write_data;
    } t_req;

    typedef struct packed {
        logic [31:0] read_data;
        logic [1:0]  status;
        logic        mmu_on;
        logic        high_vectors;
        logic        invalidate_mappings;
    } t_rsp;

    typedef struct packed {
        logic [9:0]  ctrl;
        logic [31:0] csel;
        logic [31:0] dtcm;
        logic [31:0] itcm;
        logic [31:0] ctx;
        logic [31:0] tid;
    } t_state;

    // supported crn 7 maintenance ops: op2 mask per crm
    function automatic logic maint_known(input logic [3:0] crm, input logic [2:0] op2);
        logic [7:0] m;
        case (crm)
            4'd0:    m = 8'h10;
            4'd5:    m = 8'hd7;
            4'd6:    m = 8'h07;
            4'd7:    m = 8'h07;
            4'd10:   m = 8'h3f;
            4'd11:   m = 8'h07;
            4'd13:   m = 8'h02;
            4'd14:   m = 8'h0f;
            4'd15:   m = 8'h07;
            default: m = 8'h00;
        endcase
        return m[op2];
    endfunction

    function automatic logic [31:0] pack_ctrl(input logic [9:0] c);
        logic [31:0] d;
        d        = '0;
        d[0]     = c[0];
        d[1]     = c[1];
        d[2]     = c[2];
        d[6:3]   = 4'hf;
        d[11]    = c[3];
        d[12]    = c[4];
        d[13]    = c[5];
        d[24:14] = CTRL_FIXED;
        d[25]    = c[6];
        d[28]    = c[7];
        d[29]    = c[8];
        d[30]    = c[9];
        return d;
    endfunction

endpackage

>>> hw/rtl/scp_decode.sv
// Access decode: read mux, write decode, status and next register state.
module scp_decode (
    input  scp_pkg::t_req   i_req,
    input  scp_pkg::t_state i_state,
    input  logic            i_variant,
    output scp_pkg::t_rsp   o_rsp,
    output scp_pkg::t_state o_state
);

    logic [31:0] rd;
    logic        rd_ok;
    logic [1:0]  wr_st;
    logic        inv;
    logic [31:0] w;

    assign w = i_req.write_data;

    always_comb begin
        rd    = '0;
        rd_ok = 1'b0;
        if (i_req.crn == 4'd1) begin
            rd    = scp_pkg::pack_ctrl(i_state.ctrl);
            rd_ok = 1'b1;
        end else if (i_req.crn == 4'd7) begin
            rd    = (i_req.crm == 4'd14) ? scp_pkg::CSTAT_VAL : '0;
            rd_ok = 1'b1;
        end else if (i_req.crn == 4'd0 && i_req.crm == 4'd0 && i_req.op1 == 3'd0) begin
            case (i_req.op2)
                3'd0: begin
                    rd    = i_variant ? scp_pkg::MIDR_V1 : scp_pkg::MIDR_V0;
                    rd_ok = 1'b1;
                end
                3'd1: begin
                    rd    = i_variant ? scp_pkg::CTR_V1 : scp_pkg::CTR_V0;
                    rd_ok = 1'b1;
                end
                3'd2, 3'd3: rd_ok = 1'b1;
                3'd5: begin
                    rd    = scp_pkg::MPIDR_VAL;
                    rd_ok = 1'b1;
                end
                default: rd_ok = 1'b0;
            endcase
        end else if (i_req.crn == 4'd0 && i_req.crm == 4'd0 && i_req.op1 == 3'd1) begin
            if (i_req.op2 == 3'd0) begin
                rd_ok = 1'b1;
                if (i_state.csel == 32'd0)      rd = scp_pkg::CCSID_L0;
                else if (i_state.csel == 32'd1) rd = scp_pkg::CCSID_L1;
                else if (i_state.csel == 32'd2) rd = scp_pkg::CCSID_L2;
            end else if (i_req.op2 == 3'd1) begin
                rd    = scp_pkg::CLIDR_VAL;
                rd_ok = 1'b1;
            end
        end else if (i_req.crn == 4'd0 && i_req.crm == 4'd0 && i_req.op1 == 3'd2
                     && i_req.op2 == 3'd0) begin
            rd    = i_state.csel;
            rd_ok = 1'b1;
        end else if (i_req.crn == 4'd0 && i_req.crm == 4'd1 && i_req.op1 == 3'd0) begin
            rd_ok = 1'b1;
            case (i_req.op2)
                3'd0:    rd = scp_pkg::PFR0_VAL;
                3'd4:    rd = scp_pkg::MMFR0_VAL;
                3'd5:    rd = scp_pkg::MMFR1_VAL;
                3'd7:    rd = scp_pkg::MMFR3_VAL;
                default: rd_ok = 1'b0;
            endcase
        end else if (i_req.crn == 4'd0 && i_req.crm == 4'd2 && i_req.op1 == 3'd0) begin
            rd_ok = 1'b1;
            case (i_req.op2)
                3'd0:    rd = scp_pkg::ISAR0_VAL;
                3'd3:    rd = scp_pkg::ISAR3_VAL;
                3'd5:    rd = '0;
                default: rd_ok = 1'b0;
            endcase
        end else if (i_req.crn == 4'd9 && i_req.crm == 4'd1 && i_req.op1 == 3'd0) begin
            if (i_req.op2 == 3'd0) begin
                rd    = i_state.dtcm;
                rd_ok = 1'b1;
            end else if (i_req.op2 == 3'd1) begin
                rd    = i_state.itcm;
                rd_ok = 1'b1;
            end
        end else if (i_req.crn == 4'd13 && i_req.crm == 4'd0 && i_req.op1 == 3'd0) begin
            if (i_req.op2 == 3'd1) begin
                rd    = i_state.ctx;
                rd_ok = 1'b1;
            end else if (i_req.op2 == 3'd4) begin
                rd    = i_state.tid;
                rd_ok = 1'b1;
            end
        end else if (i_req.crn == 4'd15 && i_req.crm == 4'd0 && i_req.op1 == 3'd4
                     && i_req.op2 == 3'd0) begin
            rd    = scp_pkg::CBAR_VAL;
            rd_ok = 1'b1;
        end
    end

    always_comb begin
        o_state = i_state;
        wr_st   = scp_pkg::ST_WR_UNK;
        inv     = 1'b0;
        if (i_req.req_type == scp_pkg::REQ_WRITE) begin
            if (i_req.crn == 4'd1) begin
                o_state.ctrl = {w[30], w[29], w[28], w[25], w[13], w[12], w[11],
                                w[2], w[1], w[0]};
                wr_st = |(w & scp_pkg::CTRL_BAD_MSK) ? scp_pkg::ST_FORBIDDEN : scp_pkg::ST_OK;
            end else if (i_req.crn == 4'd7) begin
                inv   = 1'b1;
                wr_st = scp_pkg::maint_known(i_req.crm, i_req.op2) ? scp_pkg::ST_OK
                                                                   : scp_pkg::ST_WR_UNK;
            end else if (i_req.crn == 4'd8) begin
                if (i_req.crm == 4'd5 || i_req.crm == 4'd6 || i_req.crm == 4'd7) begin
                    inv   = 1'b1;
                    wr_st = scp_pkg::ST_OK;
                end
            end else if (i_req.crn == 4'd0 && i_req.crm == 4'd0 && i_req.op1 == 3'd2
                         && i_req.op2 == 3'd0) begin
                o_state.csel = w;
                wr_st        = scp_pkg::ST_OK;
            end else if (i_req.crn == 4'd9 && i_req.crm == 4'd1 && i_req.op1 == 3'd0) begin
                if (i_req.op2 == 3'd0) begin
                    o_state.dtcm = w;
                    wr_st        = scp_pkg::ST_OK;
                end else if (i_req.op2 == 3'd1) begin
                    o_state.itcm = w;
                    wr_st        = scp_pkg::ST_OK;
                end
            end else if (i_req.crn == 4'd9 && i_req.crm == 4'd2 && i_req.op1 == 3'd0
                         && i_req.op2 == 3'd0) begin
                wr_st = scp_pkg::ST_OK;
            end else if (i_req.crn == 4'd10 && i_req.crm == 4'd2 && i_req.op1 == 3'd0
                         && (i_req.op2 == 3'd0 || i_req.op2 == 3'd1)) begin
                // remap: accepted, not stored
                wr_st = scp_pkg::ST_OK;
            end else if (i_req.crn == 4'd13 && i_req.crm == 4'd0 && i_req.op1 == 3'd0) begin
                if (i_req.op2 == 3'd1) begin
                    o_state.ctx = w;
                    wr_st       = scp_pkg::ST_OK;
                end else if (i_req.op2 == 3'd4) begin
                    o_state.tid = w;
                    wr_st       = scp_pkg::ST_OK;
                end
            end
        end
    end

    always_comb begin
        if (i_req.req_type == scp_pkg::REQ_WRITE) begin
            o_rsp.read_data = '0;
            o_rsp.status    = wr_st;
        end else begin
            o_rsp.read_data = rd_ok ? rd : '0;
            o_rsp.status    = rd_ok ? scp_pkg::ST_OK : scp_pkg::ST_RD_UNK;
        end
        o_rsp.mmu_on              = o_state.ctrl[0];
        o_rsp.high_vectors        = o_state.ctrl[5];
        o_rsp.invalidate_mappings = inv;
    end

endmodule

>>> hw/rtl/system_control_coprocessor_regs.sv
// Top level: system control coprocessor register block with APB configuration port.
// Pipeline: an accepted word is held in the input register, then its result and strobe are registered.
// Throughput: one word per cycle; busy is never raised, set by the single decode stage
// between the input register and the result register, which also updates the state.
// Reset (i_rst_n low, synchronous): control flags, selector, context and thread clear,
// both TCM words load 0x14, core variant clears, pending words are dropped.
module system_control_coprocessor_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  scp_pkg::t_req               i_req,
    output logic                        o_valid,
    output scp_pkg::t_rsp               o_rsp,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [scp_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    logic            r_in_vld;
    scp_pkg::t_req   r_in_req;
    logic            r_valid;
    scp_pkg::t_rsp   r_rsp;
    scp_pkg::t_state r_state;
    logic            r_variant;

    scp_pkg::t_rsp   n_rsp;
    scp_pkg::t_state n_state;
    logic            cfg_wr;
    logic            reg_hit;

    assign busy    = 1'b0;
    assign pready  = 1'b1;
    assign reg_hit = (paddr[scp_pkg::PADDR_W-1] == scp_pkg::REG_VARIANT);
    assign cfg_wr  = psel & penable & pwrite & pready & reg_hit;
    assign prdata  = reg_hit ? {31'd0, r_variant} : 32'd0;

    scp_decode u_decode (
        .i_req     (r_in_req),
        .i_state   (r_state),
        .i_variant (r_variant),
        .o_rsp     (n_rsp),
        .o_state   (n_state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_valid  <= 1'b0;
            r_variant <= 1'b0;
            r_state.ctrl <= '0;
            r_state.csel <= '0;
            r_state.dtcm <= scp_pkg::TCM_RESET;
            r_state.itcm <= scp_pkg::TCM_RESET;
            r_state.ctx  <= '0;
            r_state.tid  <= '0;
        end else begin
            r_in_vld <= start & ~busy;
            r_valid  <= r_in_vld;
            if (cfg_wr) begin
                r_variant <= pwdata[0];
            end
            if (r_in_vld) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start & ~busy) begin
            r_in_req <= i_req;
        end
        if (r_in_vld) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

    a_strobe_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_in_vld == $past(start)))
        else $error("input stage valid does not follow start");

    a_mmu_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_rsp.mmu_on == r_state.ctrl[0] && o_rsp.high_vectors == r_state.ctrl[5]))
        else $error("reported flags differ from stored control flags");

    a_inv_on_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.invalidate_mappings) |->
            (o_rsp.read_data == 32'd0 && o_rsp.status != scp_pkg::ST_RD_UNK))
        else $error("invalidate pulse on a read word");

    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$past(r_in_vld)) |-> $stable(r_state))
        else $error("register state changed without an access");

endmodule

>>> tb/sv/system_control_coprocessor_regs_tb.sv
// Testbench for the coprocessor register block: directed table, random words, checking.
module system_control_coprocessor_regs_tb;

    localparam int STALL_LIMIT  = 500;
    localparam int DRAIN_CYCLES = 6;
    localparam int PHASE_WORDS  = 600;
    localparam int MAX_PRINTS   = 20;
    localparam logic [scp_pkg::PADDR_W-1:0] VARIANT_ADDR = {scp_pkg::REG_VARIANT, 2'b00};
    // op2 masks of the supported crn 7 maintenance ops, indexed by crm
    localparam logic [15:0][7:0] MAINT_OPS = {
        8'h07, 8'h0f, 8'h02, 8'h00, 8'h07, 8'h3f, 8'h00, 8'h00,
        8'h07, 8'h07, 8'hd7, 8'h00, 8'h00, 8'h00, 8'h00, 8'h10
    };

    typedef struct packed {
        scp_pkg::t_req req;
        logic          has_rsp;
        scp_pkg::t_rsp rsp;
    } t_dir_row;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        start;
    logic                        busy;
    scp_pkg::t_req               i_req;
    logic                        o_valid;
    scp_pkg::t_rsp               o_rsp;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [scp_pkg::PADDR_W-1:0] paddr;
    logic [31:0]                 pwdata;
    logic [31:0]                 prdata;
    logic                        pready;

    logic                        use_fixed;
    scp_pkg::t_rsp               fixed_rsp;

    // predictor copy of the register state
    logic               core_var;
    logic [9:0]         ctrl_flags;
    logic [31:0]        cache_sel;
    logic [31:0]        dtcm_word;
    logic [31:0]        itcm_word;
    logic [31:0]        ctx_id;
    logic [31:0]        thread_id;

    scp_pkg::t_rsp      pending_rsp[$];
    t_dir_row           dir_rows[$];

    int n_err;
    int n_acc;
    int n_wr;
    int n_inv;
    int n_forb;
    int n_rd_unk;
    int n_checked;
    int idle_cycles;

    system_control_coprocessor_regs i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_valid (o_valid),
        .o_rsp   (o_rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic scp_pkg::t_rsp predict_access(input scp_pkg::t_req a);
        scp_pkg::t_rsp r;
        logic          hit;
        logic [31:0]   d;
        r   = '0;
        d   = '0;
        hit = 1'b1;
        if (a.req_type == scp_pkg::REQ_WRITE) begin
            r.status = scp_pkg::ST_WR_UNK;
            if (a.crn == 4'd1) begin
                ctrl_flags = {a.write_data[30:28], a.write_data[25], a.write_data[13:11],
                              a.write_data[2:0]};
                r.status = (|(a.write_data & scp_pkg::CTRL_BAD_MSK)) ? scp_pkg::ST_FORBIDDEN
                                                                     : scp_pkg::ST_OK;
            end else if (a.crn == 4'd7) begin
                r.invalidate_mappings = 1'b1;
                r.status = MAINT_OPS[a.crm][a.op2] ? scp_pkg::ST_OK : scp_pkg::ST_WR_UNK;
            end else if (a.crn == 4'd8) begin
                if (a.crm >= 4'd5 && a.crm <= 4'd7) begin
                    r.invalidate_mappings = 1'b1;
                    r.status = scp_pkg::ST_OK;
                end
            end else if (a.crn == 4'd0 && a.crm == 4'd0 && a.op1 == 3'd2 && a.op2 == 3'd0) begin
                cache_sel = a.write_data;
                r.status  = scp_pkg::ST_OK;
            end else if (a.crn == 4'd9 && a.crm == 4'd1 && a.op1 == 3'd0 && a.op2 == 3'd0) begin
                dtcm_word = a.write_data;
                r.status  = scp_pkg::ST_OK;
            end else if (a.crn == 4'd9 && a.crm == 4'd1 && a.op1 == 3'd0 && a.op2 == 3'd1) begin
                itcm_word = a.write_data;
                r.status  = scp_pkg::ST_OK;
            end else if (a.crn == 4'd9 && a.crm == 4'd2 && a.op1 == 3'd0 && a.op2 == 3'd0) begin
                r.status = scp_pkg::ST_OK;
            end else if (a.crn == 4'd10 && a.crm == 4'd2 && a.op1 == 3'd0 && a.op2 <= 3'd1) begin
                r.status = scp_pkg::ST_OK;
            end else if (a.crn == 4'd13 && a.crm == 4'd0 && a.op1 == 3'd0 && a.op2 == 3'd1) begin
                ctx_id   = a.write_data;
                r.status = scp_pkg::ST_OK;
            end else if (a.crn == 4'd13 && a.crm == 4'd0 && a.op1 == 3'd0 && a.op2 == 3'd4) begin
                thread_id = a.write_data;
                r.status  = scp_pkg::ST_OK;
            end
        end else begin
            if (a.crn == 4'd1) begin
                d = {1'b0, ctrl_flags[9:7], 2'b00, ctrl_flags[6], scp_pkg::CTRL_FIXED,
                     ctrl_flags[5:3], 4'h0, 4'hf, ctrl_flags[2:0]};
            end else if (a.crn == 4'd7) begin
                d = (a.crm == 4'd14) ? scp_pkg::CSTAT_VAL : 32'd0;
            end else if (a.crn == 4'd0 && a.crm == 4'd0 && a.op1 == 3'd0) begin
                case (a.op2)
                    3'd0:       d = core_var ? scp_pkg::MIDR_V1 : scp_pkg::MIDR_V0;
                    3'd1:       d = core_var ? scp_pkg::CTR_V1 : scp_pkg::CTR_V0;
                    3'd2, 3'd3: d = 32'd0;
                    3'd5:       d = scp_pkg::MPIDR_VAL;
                    default:    hit = 1'b0;
                endcase
            end else if (a.crn == 4'd0 && a.crm == 4'd0 && a.op1 == 3'd1) begin
                if (a.op2 == 3'd0) begin
                    case (cache_sel)
                        32'd0:   d = scp_pkg::CCSID_L0;
                        32'd1:   d = scp_pkg::CCSID_L1;
                        32'd2:   d = scp_pkg::CCSID_L2;
                        default: d = 32'd0;
                    endcase
                end else if (a.op2 == 3'd1) begin
                    d = scp_pkg::CLIDR_VAL;
                end else begin
                    hit = 1'b0;
                end
            end else if (a.crn == 4'd0 && a.crm == 4'd0 && a.op1 == 3'd2 && a.op2 == 3'd0) begin
                d = cache_sel;
            end else if (a.crn == 4'd0 && a.crm == 4'd1 && a.op1 == 3'd0) begin
                case (a.op2)
                    3'd0:    d = scp_pkg::PFR0_VAL;
                    3'd4:    d = scp_pkg::MMFR0_VAL;
                    3'd5:    d = scp_pkg::MMFR1_VAL;
                    3'd7:    d = scp_pkg::MMFR3_VAL;
                    default: hit = 1'b0;
                endcase
            end else if (a.crn == 4'd0 && a.crm == 4'd2 && a.op1 == 3'd0) begin
                case (a.op2)
                    3'd0:    d = scp_pkg::ISAR0_VAL;
                    3'd3:    d = scp_pkg::ISAR3_VAL;
                    3'd5:    d = 32'd0;
                    default: hit = 1'b0;
                endcase
            end else if (a.crn == 4'd9 && a.crm == 4'd1 && a.op1 == 3'd0) begin
                if (a.op2 == 3'd0) d = dtcm_word;
                else if (a.op2 == 3'd1) d = itcm_word;
                else hit = 1'b0;
            end else if (a.crn == 4'd13 && a.crm == 4'd0 && a.op1 == 3'd0) begin
                if (a.op2 == 3'd1) d = ctx_id;
                else if (a.op2 == 3'd4) d = thread_id;
                else hit = 1'b0;
            end else if (a.crn == 4'd15 && a.crm == 4'd0 && a.op1 == 3'd4 && a.op2 == 3'd0) begin
                d = scp_pkg::CBAR_VAL;
            end else begin
                hit = 1'b0;
            end
            r.read_data = hit ? d : 32'd0;
            r.status    = hit ? scp_pkg::ST_OK : scp_pkg::ST_RD_UNK;
        end
        r.mmu_on       = ctrl_flags[0];
        r.high_vectors = ctrl_flags[5];
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (n_err < MAX_PRINTS)
            $display("mismatch on %s: got %h, want %h (result %0d)", what, got, want, n_checked);
        n_err++;
    endtask

    // result check, then prediction of the word taken at this edge, then the watchdog
    always @(posedge i_clk) begin
        scp_pkg::t_rsp want;
        scp_pkg::t_rsp pred;
        if (i_rst_n && o_valid) begin
            if (pending_rsp.size() == 0) begin
                flag_mismatch("unexpected result", o_rsp.read_data, 32'd0);
            end else begin
                want = pending_rsp.pop_front();
                if (o_rsp.read_data !== want.read_data)
                    flag_mismatch("read_data", o_rsp.read_data, want.read_data);
                if (o_rsp.status !== want.status)
                    flag_mismatch("status", 32'(o_rsp.status), 32'(want.status));
                if (o_rsp.mmu_on !== want.mmu_on)
                    flag_mismatch("mmu_on", 32'(o_rsp.mmu_on), 32'(want.mmu_on));
                if (o_rsp.high_vectors !== want.high_vectors)
                    flag_mismatch("high_vectors", 32'(o_rsp.high_vectors),
                                  32'(want.high_vectors));
                if (o_rsp.invalidate_mappings !== want.invalidate_mappings)
                    flag_mismatch("invalidate_mappings", 32'(o_rsp.invalidate_mappings),
                                  32'(want.invalidate_mappings));
            end
            n_checked++;
        end
        if (i_rst_n && start && !busy) begin
            pred = predict_access(i_req);
            pending_rsp.push_back(use_fixed ? fixed_rsp : pred);
            n_acc++;
            if (i_req.req_type == scp_pkg::REQ_WRITE) n_wr++;
            if (pred.invalidate_mappings) n_inv++;
            if (pred.status == scp_pkg::ST_FORBIDDEN) n_forb++;
            if (pred.status == scp_pkg::ST_RD_UNK) n_rd_unk++;
        end
        if ((i_rst_n && start && !busy) || o_valid) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles == STALL_LIMIT) begin
                $display("timeout: %0d cycles with no word moving", STALL_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    function automatic scp_pkg::t_req acc(input logic rt, input int crn, input int op1,
                                          input int crm, input int op2,
                                          input logic [31:0] wd);
        scp_pkg::t_req a;
        a.req_type   = rt;
        a.crn        = 4'(crn);
        a.op1        = 3'(op1);
        a.crm        = 4'(crm);
        a.op2        = 3'(op2);
        a.write_data = wd;
        return a;
    endfunction

    function automatic scp_pkg::t_rsp res(input logic [31:0] rd, input logic [1:0] st,
                                          input logic m, input logic v, input logic inv);
        scp_pkg::t_rsp r;
        r.read_data           = rd;
        r.status              = st;
        r.mmu_on              = m;
        r.high_vectors        = v;
        r.invalidate_mappings = inv;
        return r;
    endfunction

    task automatic add_row(input scp_pkg::t_req a, input logic has_rsp,
                           input scp_pkg::t_rsp r);
        t_dir_row row;
        row.req     = a;
        row.has_rsp = has_rsp;
        row.rsp     = r;
        dir_rows.push_back(row);
    endtask

    function automatic scp_pkg::t_req rand_access();
        scp_pkg::t_req a;
        logic [63:0]   raw;
        raw = {$urandom, $urandom};
        a   = raw[46:0];
        case ($urandom_range(0, 9))
            0: begin
                a.crn = 4'd1;
                if ($urandom_range(0, 1) == 0) a.write_data &= ~scp_pkg::CTRL_BAD_MSK;
            end
            1: a.crn = 4'd7;
            2: begin
                a.crn = 4'd8;
                a.crm = 4'($urandom_range(4, 8));
            end
            3: begin
                a.crn = 4'd0;
                a.crm = 4'($urandom_range(0, 2));
                a.op1 = 3'($urandom_range(0, 2));
            end
            4: begin
                a.crn = 4'd0;
                a.crm = 4'd0;
                a.op1 = 3'($urandom_range(1, 2));
                if ($urandom_range(0, 3) != 0) a.op2 = 3'd0;
                if ($urandom_range(0, 3) != 0) a.write_data = 32'($urandom_range(0, 3));
            end
            5: begin
                a.crn = 4'd9;
                a.op1 = 3'd0;
                a.crm = 4'($urandom_range(1, 2));
                a.op2 = 3'($urandom_range(0, 2));
            end
            6: begin
                a.crn = 4'd13;
                a.crm = 4'd0;
                a.op1 = 3'd0;
                if ($urandom_range(0, 3) != 0) a.op2 = ($urandom_range(0, 1) != 0) ? 3'd1 : 3'd4;
            end
            7: begin
                if ($urandom_range(0, 1) != 0) begin
                    a.crn = 4'd10;
                    a.crm = 4'd2;
                    a.op1 = 3'd0;
                    a.op2 = 3'($urandom_range(0, 2));
                end else begin
                    a.crn = 4'd15;
                    a.crm = 4'd0;
                    a.op1 = 3'd4;
                    a.op2 = 3'd0;
                end
            end
            default: ;
        endcase
        return a;
    endfunction

    task automatic send_word(input scp_pkg::t_req a, input logic fix,
                             input scp_pkg::t_rsp frsp);
        start     <= 1'b1;
        i_req     <= a;
        use_fixed <= fix;
        fixed_rsp <= frsp;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic hold_off(input int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_variant(input logic v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= VARIANT_ADDR;
        pwdata  <= {31'd0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        core_var = v;
    endtask

    initial begin
        logic          gaps_on;
        scp_pkg::t_rsp none;
        none        = '0;
        n_err       = 0;
        n_acc       = 0;
        n_wr        = 0;
        n_inv       = 0;
        n_forb      = 0;
        n_rd_unk    = 0;
        n_checked   = 0;
        idle_cycles = 0;
        core_var    = 1'b0;
        ctrl_flags  = '0;
        cache_sel   = '0;
        dtcm_word   = scp_pkg::TCM_RESET;
        itcm_word   = scp_pkg::TCM_RESET;
        ctx_id      = '0;
        thread_id   = '0;
        gaps_on     = 1'b0;

        i_rst_n   <= 1'b0;
        start     <= 1'b0;
        i_req     <= '0;
        use_fixed <= 1'b0;
        fixed_rsp <= '0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;

        add_row(acc(scp_pkg::REQ_READ, 0, 0, 0, 0, 32'd0), 1'b1,
                res(scp_pkg::MIDR_V0, scp_pkg::ST_OK, 1'b0, 1'b0, 1'b0));
        add_row(acc(scp_pkg::REQ_READ, 1, 0, 0, 0, 32'd0), 1'b1,
                res(32'h00c5_0078, scp_pkg::ST_OK, 1'b0, 1'b0, 1'b0));
        add_row(acc(scp_pkg::REQ_READ, 9, 0, 1, 0, 32'd0), 1'b1,
                res(scp_pkg::TCM_RESET, scp_pkg::ST_OK, 1'b0, 1'b0, 1'b0));
        add_row(acc(scp_pkg::REQ_READ, 9, 0, 1, 1, 32'd0), 1'b1,
                res(scp_pkg::TCM_RESET, scp_pkg::ST_OK, 1'b0, 1'b0, 1'b0));
        add_row(acc(scp_pkg::REQ_READ, 15, 7, 15, 7, 32'd0), 1'b1,
                res(32'd0, scp_pkg::ST_RD_UNK, 1'b0, 1'b0, 1'b0));
        add_row(acc(scp_pkg::REQ_WRITE, 15, 7, 15, 7, '1), 1'b1,
                res(32'd0, scp_pkg::ST_WR_UNK, 1'b0, 1'b0, 1'b0));
        add_row(acc(scp_pkg::REQ_READ, 15, 4, 0, 0, 32'd0), 1'b1,
                res(scp_pkg::CBAR_VAL, scp_pkg::ST_OK, 1'b0, 1'b0, 1'b0));
        add_row(acc(scp_pkg::REQ_READ, 7, 0, 14, 0, 32'd0), 1'b1,
                res(scp_pkg::CSTAT_VAL, scp_pkg::ST_OK, 1'b0, 1'b0, 1'b0));
        add_row(acc(scp_pkg::REQ_READ, 0, 0, 0, 5, 32'd0), 1'b1,
                res(scp_pkg::MPIDR_VAL, scp_pkg::ST_OK, 1'b0, 1'b0, 1'b0));
        // control reg is decoded on crn alone
        add_row(acc(scp_pkg::REQ_WRITE, 1, 7, 15, 7, '1), 1'b1,
                res(32'd0, scp_pkg::ST_FORBIDDEN, 1'b1, 1'b1, 1'b0));
        add_row(acc(scp_pkg::REQ_READ, 1, 0, 0, 0, 32'd0), 1'b0, none);
        add_row(acc(scp_pkg::REQ_WRITE, 1, 0, 0, 0, 32'h0000_2001), 1'b1,
                res(32'd0, scp_pkg::ST_OK, 1'b1, 1'b1, 1'b0));
        add_row(acc(scp_pkg::REQ_WRITE, 7, 0, 5, 0, 32'd0), 1'b1,
                res(32'd0, scp_pkg::ST_OK, 1'b1, 1'b1, 1'b1));
        add_row(acc(scp_pkg::REQ_WRITE, 7, 7, 1, 0, 32'd0), 1'b1,
                res(32'd0, scp_pkg::ST_WR_UNK, 1'b1, 1'b1, 1'b1));
        add_row(acc(scp_pkg::REQ_WRITE, 8, 0, 6, 0, 32'd0), 1'b1,
                res(32'd0, scp_pkg::ST_OK, 1'b1, 1'b1, 1'b1));
        add_row(acc(scp_pkg::REQ_WRITE, 8, 0, 4, 0, 32'd0), 1'b1,
                res(32'd0, scp_pkg::ST_WR_UNK, 1'b1, 1'b1, 1'b0));
        add_row(acc(scp_pkg::REQ_WRITE, 0, 2, 0, 0, 32'd1), 1'b0, none);
        add_row(acc(scp_pkg::REQ_READ, 0, 1, 0, 0, 32'd0), 1'b0, none);
        // selector past the last cache level
        add_row(acc(scp_pkg::REQ_WRITE, 0, 2, 0, 0, 32'd5), 1'b0, none);
        add_row(acc(scp_pkg::REQ_READ, 0, 1, 0, 0, 32'd0), 1'b0, none);
        add_row(acc(scp_pkg::REQ_READ, 0, 2, 0, 0, 32'd0), 1'b0, none);
        add_row(acc(scp_pkg::REQ_WRITE, 10, 0, 2, 1, '1), 1'b0, none);
        add_row(acc(scp_pkg::REQ_WRITE, 13, 0, 0, 1, 32'hdead_beef), 1'b0, none);
        add_row(acc(scp_pkg::REQ_READ, 13, 0, 0, 1, 32'd0), 1'b0, none);
        add_row(acc(scp_pkg::REQ_WRITE, 1, 0, 0, 0, 32'd0), 1'b1,
                res(32'd0, scp_pkg::ST_OK, 1'b0, 1'b0, 1'b0));

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) begin
            send_word(dir_rows[k].req, dir_rows[k].has_rsp, dir_rows[k].rsp);
        end

        for (int ph = 0; ph < 3; ph++) begin
            drain();
            set_variant((ph % 2 == 0) ? 1'b1 : 1'b0);
            for (int k = 0; k < PHASE_WORDS; k++) begin
                if (k % 40 == 0) gaps_on = ($urandom_range(0, 2) != 0);
                if (ph == 2 && k >= PHASE_WORDS / 2) gaps_on = 1'b0;
                send_word(rand_access(), 1'b0, none);
                if (gaps_on && $urandom_range(0, 3) == 0) hold_off(int'($urandom_range(1, 6)));
            end
        end
        drain();

        $display("covered %0d accesses (%0d writes, %0d unknown reads) over both core variants",
                 n_acc, n_wr, n_rd_unk);
        $display("%0d invalidate pulses, %0d forbidden control writes, %0d results checked",
                 n_inv, n_forb, n_checked);
        if (n_err == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
